// ----- rtl/pmvd_pkg.sv -----
// pmvd_pkg: shared types and constants of the presence mask varint decoder
// no dependencies; imported by every module of the block

package pmvd_pkg;

    // varint byte layout
    localparam int unsigned GROUP_BITS   = 7;
    localparam logic [7:0]  GROUP_MASK   = 8'h7f;
    localparam int unsigned MORE_BIT     = 7;

    // group counter: groups 0..4 land below bit 32, group 5 is the stop value
    localparam int unsigned GROUP_W      = 3;
    localparam logic [GROUP_W-1:0] GROUP_STOP = 3'd5;

    // field numbering
    localparam int unsigned ID_W         = 3;
    localparam int unsigned MAX_FIELDS   = 7;
    localparam logic [ID_W-1:0] ID_MASK  = 3'd0;
    localparam logic [ID_W-1:0] ID_LAST_NARROW = 3'd3;  // data fields 0..2 are 16 bit

    localparam int unsigned VALUE_W      = 32;
    localparam int unsigned PRESENCE_W   = 8;

    // one accepted input word
    typedef struct packed {
        logic       frame_start;
        logic [7:0] data_byte;
    } t_in_word;

    // one result word
    typedef struct packed {
        logic [ID_W-1:0]    field_id;
        logic [VALUE_W-1:0] field_value;
        logic               record_done;
    } t_result;

endpackage

// ----- rtl/pmvd_in_reg.sv -----
// pmvd_in_reg: input register stage of the presence mask varint decoder
// depends on pmvd_pkg for the input word type

module pmvd_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  pmvd_pkg::t_in_word i_word,
    output logic               o_valid,
    output pmvd_pkg::t_in_word o_word,
    input  logic               i_take
);
    import pmvd_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_word r_word;

    // room when empty or when the held word leaves this cycle
    assign o_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ----- rtl/pmvd_step.sv -----
// pmvd_step: parser state and per-byte decode of the presence mask varint decoder
// depends on pmvd_pkg for types and varint constants

module pmvd_step #(
    parameter int unsigned FIELD_COUNT = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  pmvd_pkg::t_in_word i_word,
    output logic               o_res_valid,
    output pmvd_pkg::t_result  o_res
);
    import pmvd_pkg::*;

    localparam logic [ID_W-1:0] LAST_PHASE = ID_W'(FIELD_COUNT);

    logic [ID_W-1:0]       r_phase,    n_phase;
    logic [PRESENCE_W-1:0] r_presence, n_presence;
    logic [VALUE_W-1:0]    r_acc,      n_acc;
    logic [GROUP_W-1:0]    r_group,    n_group;
    logic                  r_finished, n_finished;

    logic [ID_W-1:0]       base_phase;
    logic [PRESENCE_W-1:0] base_presence;
    logic [VALUE_W-1:0]    base_acc;
    logic [GROUP_W-1:0]    base_group;
    logic                  base_finished;
    logic [VALUE_W-1:0]    acc_sum;
    logic [5:0]            shift_amt;
    logic [PRESENCE_W-1:0] look_mask;
    logic [ID_W-1:0]       nxt_idx;
    logic                  nxt_found;

    always_comb begin
        // a frame start clears everything before the byte is used
        base_phase    = r_phase;
        base_presence = r_presence;
        base_acc      = r_acc;
        base_group    = r_group;
        base_finished = r_finished;
        if (i_word.frame_start) begin
            base_phase    = ID_MASK;
            base_presence = '0;
            base_acc      = '0;
            base_group    = '0;
            base_finished = 1'b0;
        end

        // merge the 7-bit group at its position
        shift_amt = 6'({3'b000, base_group} * 6'(GROUP_BITS));
        acc_sum   = base_acc;
        if (base_group < GROUP_STOP) begin
            acc_sum = base_acc | (VALUE_W'(i_word.data_byte & GROUP_MASK) << shift_amt);
        end

        // presence bits to search: fresh mask while finishing the mask itself
        look_mask = (base_phase == ID_MASK) ? acc_sum[PRESENCE_W-1:0] : base_presence;

        // lowest set field at or above the current phase, below the field count
        nxt_idx   = '0;
        nxt_found = 1'b0;
        for (int i = MAX_FIELDS - 1; i >= 0; i--) begin
            if (look_mask[i] && (ID_W'(i) >= base_phase) && (i < FIELD_COUNT)) begin
                nxt_idx   = ID_W'(i);
                nxt_found = 1'b1;
            end
        end

        n_phase     = r_phase;
        n_presence  = r_presence;
        n_acc       = r_acc;
        n_group     = r_group;
        n_finished  = r_finished;
        o_res_valid = 1'b0;
        o_res.field_id    = base_phase;
        o_res.record_done = !nxt_found;
        if (base_phase == ID_MASK) begin
            o_res.field_value = VALUE_W'(acc_sum[PRESENCE_W-1:0]);
        end else if (base_phase <= ID_LAST_NARROW) begin
            o_res.field_value = VALUE_W'(acc_sum[15:0]);
        end else begin
            o_res.field_value = acc_sum;
        end

        if (i_fire) begin
            n_phase    = base_phase;
            n_presence = base_presence;
            n_acc      = base_acc;
            n_group    = base_group;
            n_finished = base_finished;
            priority if (base_finished) begin
                // idle: byte ignored
            end else if (base_phase > LAST_PHASE) begin
                n_finished = 1'b1;
            end else if (i_word.data_byte[MORE_BIT]) begin
                // continuation byte
                n_acc   = acc_sum;
                n_group = (base_group < GROUP_STOP) ? base_group + 1'b1 : base_group;
            end else begin
                // varint complete
                o_res_valid = 1'b1;
                if (base_phase == ID_MASK) begin
                    n_presence = acc_sum[PRESENCE_W-1:0];
                end
                n_acc      = '0;
                n_group    = '0;
                n_finished = !nxt_found;
                n_phase    = nxt_found ? nxt_idx + 1'b1 : ID_MASK;
            end
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ID_MASK;
            r_presence <= '0;
            r_acc      <= '0;
            r_group    <= '0;
            r_finished <= 1'b1;
        end else begin
            r_phase    <= n_phase;
            r_presence <= n_presence;
            r_acc      <= n_acc;
            r_group    <= n_group;
            r_finished <= n_finished;
        end
    end

endmodule

// ----- rtl/pmvd_out_reg.sv -----
// pmvd_out_reg: result register of the presence mask varint decoder
// depends on pmvd_pkg for the result type

module pmvd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  pmvd_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output pmvd_pkg::t_result o_res
);
    import pmvd_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // slot can take a new word when empty or draining this cycle
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- rtl/presence_mask_varint_decoder.sv -----
// Presence mask varint decoder: takes one byte per word and emits one word per completed
// LEB128 varint (the presence mask, then each present field). A byte goes through an input
// register, combinational decode logic, and a result register: one byte per clock sustained
// while the result port is ready. Backpressure on the result port stalls the input port.
// No clearing pass after reset; the decoder idles until a byte with frame_start set.
// depends on pmvd_pkg, pmvd_in_reg, pmvd_step, pmvd_out_reg

module presence_mask_varint_decoder #(
    parameter int unsigned FIELD_COUNT = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] frame_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] field_value
    output logic [2:0]  o_m_axis_tuser,   // [2:0] field_id
    output logic        o_m_axis_tlast    // record_done
);
    import pmvd_pkg::*;

    t_in_word in_word;
    t_in_word held_word;
    t_result  step_res;
    t_result  out_res;
    logic     held_valid;
    logic     out_free;
    logic     step_fire;
    logic     step_res_valid;

    assign in_word.data_byte   = i_s_axis_tdata;
    assign in_word.frame_start = i_s_axis_tuser;

    // held byte is decoded when the result slot has room
    assign step_fire = held_valid && out_free;

    pmvd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_word  (in_word),
        .o_valid (held_valid),
        .o_word  (held_word),
        .i_take  (step_fire)
    );

    pmvd_step #(
        .FIELD_COUNT (FIELD_COUNT)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (step_fire),
        .i_word      (held_word),
        .o_res_valid (step_res_valid),
        .o_res       (step_res)
    );

    pmvd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step_res_valid),
        .i_res   (step_res),
        .o_free  (out_free),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (out_res)
    );

    assign o_m_axis_tdata = out_res.field_value;
    assign o_m_axis_tuser = out_res.field_id;
    assign o_m_axis_tlast = out_res.record_done;

`ifndef ASSERT_OFF
    // no field number beyond the configured count
    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser <= 3'(FIELD_COUNT)))
        else $error("field id out of range");

    // the highest field always closes its record
    a_last_field_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == 3'(FIELD_COUNT))) |-> o_m_axis_tlast)
        else $error("last field without record_done");

    // mask is 8 bit, fields 0..2 are 16 bit
    a_value_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser <= ID_LAST_NARROW)) |->
        ((o_m_axis_tdata[31:16] == 16'h0) &&
         ((o_m_axis_tuser != ID_MASK) || (o_m_axis_tdata[15:8] == 8'h0))))
        else $error("field value wider than its field");
`endif

endmodule
